### rtl/ptd_pkg.sv
// Shared types and constants for the PMT teletext descriptor parser.
// Depends on nothing; every other file uses it.
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int MAX_SECTION_BYTES = 1024;
    localparam int POS_W             = $clog2(MAX_SECTION_BYTES + 1);
    localparam int CMP_W             = ((POS_W > 13) ? POS_W : 13) + 1;
    localparam int HDR_LEN           = 12;
    localparam int QUEUE_DEPTH       = 2;

    localparam int BYTE_W  = 8;
    localparam int PID_W   = 13;
    localparam int LANG_W  = 24;
    localparam int PTYPE_W = 5;
    localparam int MAG_W   = 3;
    localparam int CNT_W   = 8;
    localparam int SLEN_W  = 10;
    localparam int LEN12_W = 12;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-3:0] REG_DECIMAL_PAGE_REMAP = '0;

    localparam logic [POS_W-1:0] POS_SLEN_HI = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SLEN_LO = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CUR     = POS_W'(5);
    localparam logic [POS_W-1:0] POS_PIL_HI  = POS_W'(10);
    localparam logic [POS_W-1:0] POS_PIL_LO  = POS_W'(11);

    localparam logic [2:0] ES_HDR_TYPE    = 3'd0;
    localparam logic [2:0] ES_HDR_PID_HI  = 3'd1;
    localparam logic [2:0] ES_HDR_PID_LO  = 3'd2;
    localparam logic [2:0] ES_HDR_LEN_HI  = 3'd3;
    localparam logic [2:0] ES_HDR_LEN_LO  = 3'd4;
    localparam logic [2:0] ENTRY_HDR_BYTES = 3'd4;

    localparam logic [7:0] TAG_TELETEXT   = 8'h56;
    localparam logic [7:0] TYPE_PRIVATE   = 8'h06;
    localparam logic [7:0] PAGE_REMAP_LO  = 8'h50;
    localparam logic [7:0] PAGE_REMAP_HI  = 8'h59;
    localparam logic [7:0] PAGE_REMAP_OFS = 8'h30;
    localparam logic [7:0] ENTRY_MAX      = 8'hff;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PROG_INFO,
        PH_ES_HDR,
        PH_ES_SKIP,
        PH_DESC_TAG,
        PH_DESC_LEN,
        PH_DESC_BODY
    } t_phase;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [LANG_W-1:0] lang;
        logic [BYTE_W-1:0] attr_byte;
        logic [BYTE_W-1:0] page;
        logic [CNT_W-1:0]  count;
    } t_entry;

endpackage

### rtl/ptd_if.sv
// Handshake interfaces for section bytes in and teletext entries out.
// Depends on ptd_pkg for field widths.
`timescale 1ns / 1ps

interface ptd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [ptd_pkg::BYTE_W-1:0]    section_byte;
    logic                          section_start;

    modport source (output valid, section_byte, section_start, input ready);
    modport sink   (input valid, section_byte, section_start, output ready);
endinterface

interface ptd_result_if;
    logic                          valid;
    logic                          ready;
    logic [ptd_pkg::PID_W-1:0]     stream_pid;
    logic [ptd_pkg::LANG_W-1:0]    language_code;
    logic [ptd_pkg::PTYPE_W-1:0]   page_type;
    logic [ptd_pkg::MAG_W-1:0]     magazine;
    logic [ptd_pkg::BYTE_W-1:0]    page_number;
    logic                          page_was_remapped;
    logic [ptd_pkg::CNT_W-1:0]     entry_count;

    modport source (output valid, stream_pid, language_code, page_type, magazine,
                    page_number, page_was_remapped, entry_count, input ready);
    modport sink   (input valid, stream_pid, language_code, page_type, magazine,
                    page_number, page_was_remapped, entry_count, output ready);
endinterface

### rtl/pmt_teletext_descriptor_parser.sv
// Top level: takes one section byte per cycle while the queue has room; a teletext
// entry passes through the queue and the output register to a result beat, held until taken.
// Throughput is one byte per cycle, set by the byte-serial parser; input
// ready drops only while the two-entry queue is full. Synchronous active-low
// reset clears parser state, queue and output valid; the remap register resets to 0.
`timescale 1ns / 1ps

module pmt_teletext_descriptor_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ptd_byte_if.sink                            i_byte,
    ptd_result_if.source                        o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptd_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [ptd_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [ptd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import ptd_pkg::*;

    logic     r_remap;
    logic     w_cfg_wr;
    logic     w_reg_sel;
    logic     w_push;
    logic     w_pop;
    logic     w_q_full;
    logic     w_q_empty;
    t_entry   w_front_entry;
    t_entry   w_queue_entry;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_DECIMAL_PAGE_REMAP);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = w_reg_sel ? {{(CFG_DATA_W-1){1'b0}}, r_remap} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remap <= 1'b0;
        end else if (w_cfg_wr && w_reg_sel) begin
            r_remap <= pwdata[0];
        end
    end

    ptd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_entry  (w_front_entry)
    );

    ptd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .i_pop   (w_pop),
        .o_entry (w_queue_entry),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    ptd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_remap   (r_remap),
        .i_entry   (w_queue_entry),
        .i_q_empty (w_q_empty),
        .o_pop     (w_pop),
        .o_result  (o_result)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("entry pushed into a full queue");

    a_remap_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.page_was_remapped) |-> r_remap)
        else $error("page remapped while remap is disabled");

    a_remap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.page_was_remapped) |->
        (o_result.page_number >= PAGE_REMAP_LO + PAGE_REMAP_OFS &&
         o_result.page_number <= PAGE_REMAP_HI + PAGE_REMAP_OFS))
        else $error("remapped page outside the decimal range");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.entry_count != '0))
        else $error("result beat with zero entry count");

endmodule

### rtl/ptd_front.sv
// Byte-serial section parser: walks header, stream loop and descriptors.
// Pushes each complete teletext entry into the queue. Depends on ptd_pkg, ptd_if.
`timescale 1ns / 1ps

module ptd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ptd_byte_if.sink          i_byte,
    input  logic              i_q_full,
    output logic              o_push,
    output ptd_pkg::t_entry   o_entry
);
    import ptd_pkg::*;

    t_phase                r_phase, n_phase;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [SLEN_W-1:0]     r_slen, n_slen;
    logic [LEN12_W-1:0]    r_pil, n_pil;
    logic                  r_cur, n_cur;
    logic [2:0]            r_pcnt, n_pcnt;
    logic [BYTE_W-1:0]     r_stype, n_stype;
    logic [PID_W-1:0]      r_pid, n_pid;
    logic [LEN12_W-1:0]    r_esrem, n_esrem;
    logic [BYTE_W-1:0]     r_dtag, n_dtag;
    logic [BYTE_W-1:0]     r_drem, n_drem;
    logic [31:0]           r_ebytes, n_ebytes;
    logic [CNT_W-1:0]      r_entries, n_entries;

    logic                  w_acc;
    logic [BYTE_W-1:0]     w_b;
    logic [POS_W-1:0]      w_pos_inc;
    logic                  w_over;
    logic                  w_end;
    logic                  w_pil_done;
    logic [LEN12_W-1:0]    w_pil_full;
    logic [LEN12_W-1:0]    w_esrem_full;
    logic [LEN12_W-1:0]    w_esrem_dec;
    logic [BYTE_W-1:0]     w_drem_dec;
    logic                  w_es_zero;
    logic                  w_ttx_emit;
    logic [CNT_W-1:0]      w_entries_inc;

    assign i_byte.ready  = !i_q_full;
    assign w_acc         = i_byte.valid && i_byte.ready;
    assign w_b           = i_byte.section_byte;
    assign w_pos_inc     = r_pos + 1'b1;
    assign w_over        = w_pos_inc >= POS_W'(MAX_SECTION_BYTES);
    assign w_end         = (CMP_W'(w_pos_inc) + CMP_W'(1)) >= CMP_W'(r_slen);
    assign w_pil_done    = (CMP_W'(w_pos_inc) + CMP_W'(1)) >=
                           (CMP_W'(HDR_LEN) + CMP_W'(r_pil));
    assign w_pil_full    = {r_pil[11:8], w_b};
    assign w_esrem_full  = {r_esrem[11:8], w_b};
    assign w_esrem_dec   = r_esrem - 1'b1;
    assign w_drem_dec    = r_drem - 1'b1;
    assign w_es_zero     = (w_esrem_dec == '0);
    assign w_ttx_emit    = (r_dtag == TAG_TELETEXT) && (r_pcnt >= ENTRY_HDR_BYTES);
    assign w_entries_inc = (r_entries != ENTRY_MAX) ? r_entries + 1'b1 : r_entries;

    always_comb begin
        n_phase = r_phase;
        if (w_acc) begin
            priority if (i_byte.section_start) begin
                n_phase = PH_HEADER;
            end else if (r_phase == PH_IDLE) begin
                n_phase = PH_IDLE;
            end else if (w_over) begin
                n_phase = PH_IDLE;
            end else if (r_phase == PH_HEADER) begin
                if (r_pos + 1'b1 == POS_PIL_LO) begin
                    priority if (!r_cur) begin
                        n_phase = PH_IDLE;
                    end else if (w_pil_full != '0) begin
                        n_phase = PH_PROG_INFO;
                    end else begin
                        n_phase = PH_ES_HDR;
                    end
                end
            end else if (w_end) begin
                n_phase = PH_IDLE;
            end else begin
                unique case (r_phase)
                    PH_PROG_INFO: begin
                        if (w_pil_done) n_phase = PH_ES_HDR;
                    end
                    PH_ES_HDR: begin
                        if (r_pcnt >= ES_HDR_LEN_LO) begin
                            priority if (w_esrem_full == '0) begin
                                n_phase = PH_ES_HDR;
                            end else if (r_stype == TYPE_PRIVATE) begin
                                n_phase = PH_DESC_TAG;
                            end else begin
                                n_phase = PH_ES_SKIP;
                            end
                        end
                    end
                    PH_ES_SKIP: begin
                        if (w_es_zero) n_phase = PH_ES_HDR;
                    end
                    PH_DESC_TAG: begin
                        n_phase = w_es_zero ? PH_ES_HDR : PH_DESC_LEN;
                    end
                    PH_DESC_LEN: begin
                        priority if (w_es_zero) begin
                            n_phase = PH_ES_HDR;
                        end else if (w_b == '0) begin
                            n_phase = PH_DESC_TAG;
                        end else begin
                            n_phase = PH_DESC_BODY;
                        end
                    end
                    PH_DESC_BODY: begin
                        priority if (w_es_zero) begin
                            n_phase = PH_ES_HDR;
                        end else if (w_drem_dec == '0) begin
                            n_phase = PH_DESC_TAG;
                        end else begin
                            n_phase = PH_DESC_BODY;
                        end
                    end
                    PH_IDLE, PH_HEADER: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_slen    = r_slen;
        n_pil     = r_pil;
        n_cur     = r_cur;
        n_pcnt    = r_pcnt;
        n_stype   = r_stype;
        n_pid     = r_pid;
        n_esrem   = r_esrem;
        n_dtag    = r_dtag;
        n_drem    = r_drem;
        n_ebytes  = r_ebytes;
        n_entries = r_entries;
        o_push    = 1'b0;
        o_entry   = '{pid: r_pid, lang: r_ebytes[31:8], attr_byte: r_ebytes[7:0],
                      page: w_b, count: w_entries_inc};
        if (w_acc) begin
            priority if (i_byte.section_start) begin
                n_pos     = '0;
                n_slen    = '0;
                n_pil     = '0;
                n_cur     = 1'b0;
                n_pcnt    = '0;
                n_entries = '0;
            end else if (r_phase == PH_IDLE) begin
                n_pos = r_pos;
            end else if (w_over) begin
                n_pos = POS_W'(MAX_SECTION_BYTES);
            end else if (r_phase == PH_HEADER) begin
                n_pos = w_pos_inc;
                priority if (w_pos_inc == POS_SLEN_HI) begin
                    n_slen = {w_b[1:0], 8'h00};
                end else if (w_pos_inc == POS_SLEN_LO) begin
                    n_slen = {r_slen[9:8], w_b};
                end else if (w_pos_inc == POS_CUR) begin
                    n_cur = w_b[0];
                end else if (w_pos_inc == POS_PIL_HI) begin
                    n_pil = {w_b[3:0], 8'h00};
                end else if (w_pos_inc == POS_PIL_LO) begin
                    n_pil  = w_pil_full;
                    n_pcnt = '0;
                end else begin
                    n_pos = w_pos_inc;
                end
            end else begin
                n_pos = w_pos_inc;
                if (!w_end) begin
                    unique case (r_phase)
                        PH_PROG_INFO: begin
                            if (w_pil_done) n_pcnt = '0;
                        end
                        PH_ES_HDR: begin
                            priority if (r_pcnt == ES_HDR_TYPE) begin
                                n_stype = w_b;
                                n_pcnt  = r_pcnt + 1'b1;
                            end else if (r_pcnt == ES_HDR_PID_HI) begin
                                n_pid  = {w_b[4:0], 8'h00};
                                n_pcnt = r_pcnt + 1'b1;
                            end else if (r_pcnt == ES_HDR_PID_LO) begin
                                n_pid  = {r_pid[12:8], w_b};
                                n_pcnt = r_pcnt + 1'b1;
                            end else if (r_pcnt == ES_HDR_LEN_HI) begin
                                n_esrem = {w_b[3:0], 8'h00};
                                n_pcnt  = r_pcnt + 1'b1;
                            end else begin
                                n_esrem = w_esrem_full;
                                n_pcnt  = '0;
                            end
                        end
                        PH_ES_SKIP: begin
                            n_esrem = w_esrem_dec;
                            if (w_es_zero) n_pcnt = '0;
                        end
                        PH_DESC_TAG: begin
                            n_dtag  = w_b;
                            n_esrem = w_esrem_dec;
                            if (w_es_zero) n_pcnt = '0;
                        end
                        PH_DESC_LEN: begin
                            n_drem   = w_b;
                            n_pcnt   = '0;
                            n_ebytes = '0;
                            n_esrem  = w_esrem_dec;
                        end
                        PH_DESC_BODY: begin
                            n_esrem = w_esrem_dec;
                            n_drem  = w_drem_dec;
                            if (r_dtag == TAG_TELETEXT) begin
                                if (w_ttx_emit) begin
                                    o_push    = 1'b1;
                                    n_entries = w_entries_inc;
                                    n_pcnt    = '0;
                                    n_ebytes  = '0;
                                end else begin
                                    n_ebytes = {r_ebytes[23:0], w_b};
                                    n_pcnt   = r_pcnt + 1'b1;
                                end
                            end
                            if (w_es_zero) n_pcnt = '0;
                        end
                        PH_IDLE, PH_HEADER: begin
                            n_pcnt = r_pcnt;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pos     <= '0;
            r_cur     <= 1'b0;
            r_pcnt    <= '0;
            r_entries <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_cur     <= n_cur;
            r_pcnt    <= n_pcnt;
            r_entries <= n_entries;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slen   <= n_slen;
        r_pil    <= n_pil;
        r_stype  <= n_stype;
        r_pid    <= n_pid;
        r_esrem  <= n_esrem;
        r_dtag   <= n_dtag;
        r_drem   <= n_drem;
        r_ebytes <= n_ebytes;
    end

endmodule

### rtl/ptd_queue.sv
// Short FIFO of parsed entries between the parser and the output stage.
// Depends on ptd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ptd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ptd_pkg::t_entry   i_entry,
    input  logic              i_pop,
    output ptd_pkg::t_entry   o_entry,
    output logic              o_full,
    output logic              o_empty
);
    import ptd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    t_entry             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_occ == OCC_W'(QUEUE_DEPTH));
    assign o_empty = (r_occ == '0);
    assign o_entry = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = w_push ? r_wr + 1'b1 : r_wr;
        n_rd  = w_pop ? r_rd + 1'b1 : r_rd;
        n_occ = r_occ;
        if (w_push && !w_pop) n_occ = r_occ + 1'b1;
        if (w_pop && !w_push) n_occ = r_occ - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_occ <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_entry;
        end
    end

endmodule

### rtl/ptd_back.sv
// Output stage: applies the decimal page remap and holds the result beat.
// Depends on ptd_pkg and ptd_if.
`timescale 1ns / 1ps

module ptd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_remap,
    input  ptd_pkg::t_entry   i_entry,
    input  logic              i_q_empty,
    output logic              o_pop,
    ptd_result_if.source      o_result
);
    import ptd_pkg::*;

    logic                  r_valid, n_valid;
    logic [PID_W-1:0]      r_pid;
    logic [LANG_W-1:0]     r_lang;
    logic [BYTE_W-1:0]     r_attr_byte;
    logic [BYTE_W-1:0]     r_page;
    logic                  r_remapped;
    logic [CNT_W-1:0]      r_count;
    logic                  w_hit;

    assign o_pop   = !i_q_empty && (!r_valid || o_result.ready);
    assign w_hit   = i_remap && (i_entry.page >= PAGE_REMAP_LO) &&
                     (i_entry.page <= PAGE_REMAP_HI);
    assign n_valid = o_pop || (r_valid && !o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pid       <= i_entry.pid;
            r_lang      <= i_entry.lang;
            r_attr_byte <= i_entry.attr_byte;
            r_page      <= w_hit ? i_entry.page + PAGE_REMAP_OFS : i_entry.page;
            r_remapped  <= w_hit;
            r_count     <= i_entry.count;
        end
    end

    assign o_result.valid             = r_valid;
    assign o_result.stream_pid        = r_pid;
    assign o_result.language_code     = r_lang;
    assign o_result.page_type         = r_attr_byte[7:3];
    assign o_result.magazine          = r_attr_byte[2:0];
    assign o_result.page_number       = r_page;
    assign o_result.page_was_remapped = r_remapped;
    assign o_result.entry_count       = r_count;

endmodule

### verif/testbench.sv
// Self-checking bench for pmt_teletext_descriptor_parser: random and directed PMT sections
// go in one byte per beat, and teletext entries are checked against an in-bench parser.
// Depends on ptd_pkg and the ptd_byte_if / ptd_result_if interfaces.
`timescale 1ns / 1ps

module testbench;
    import ptd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CFG_ADDR_W-1:0] REMAP_ADDR = {REG_DECIMAL_PAGE_REMAP, 2'b00};

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [LANG_W-1:0]  lang;
        logic [PTYPE_W-1:0] ptype;
        logic [MAG_W-1:0]   mag;
        logic [BYTE_W-1:0]  page;
        logic               remapped;
        logic [CNT_W-1:0]   count;
    } teletext_entry_t;

    class teletext_scoreboard;
        teletext_entry_t pending_entries[$];
        int unsigned errors;
        int unsigned bytes_seen;
        int unsigned entries_expected;
        int unsigned entries_checked;
        int unsigned remapped_seen;
        bit remap_on;

        t_phase      phase;
        int          pos;
        int          sec_len;
        int          pil;
        logic        is_current;
        logic [2:0]  hdr_cnt;
        logic [7:0]  stype;
        logic [12:0] spid;
        logic [11:0] es_left;
        logic [7:0]  tag;
        logic [7:0]  desc_left;
        logic [31:0] acc;
        logic [7:0]  found;

        function new();
            clear_section();
        endfunction

        function void clear_section();
            pos = 0;
            sec_len = 0;
            pil = 0;
            is_current = 1'b0;
            phase = PH_IDLE;
            hdr_cnt = '0;
            stype = '0;
            spid = '0;
            es_left = '0;
            tag = '0;
            desc_left = '0;
            acc = '0;
            found = '0;
        endfunction

        function void to_es_header();
            phase = PH_ES_HDR;
            hdr_cnt = '0;
        endfunction

        function void push_entry(logic [7:0] page_in);
            teletext_entry_t e;
            logic [7:0] page;
            logic remapped;
            page = page_in;
            remapped = 1'b0;
            if (remap_on && page >= PAGE_REMAP_LO && page <= PAGE_REMAP_HI) begin
                page = page + PAGE_REMAP_OFS;
                remapped = 1'b1;
            end
            if (found < ENTRY_MAX) found++;
            e.pid = spid;
            e.lang = acc[31:8];
            e.ptype = acc[7:3];
            e.mag = acc[2:0];
            e.page = page;
            e.remapped = remapped;
            e.count = found;
            pending_entries.push_back(e);
            entries_expected++;
        endfunction

        function void parse_byte(logic [7:0] b, logic st);
            bytes_seen++;
            if (st) begin
                clear_section();
                phase = PH_HEADER;
                return;
            end
            if (phase == PH_IDLE) return;
            pos++;
            if (pos >= MAX_SECTION_BYTES) begin
                pos = MAX_SECTION_BYTES;
                phase = PH_IDLE;
                return;
            end
            if (phase == PH_HEADER) begin
                case (pos)
                    int'(POS_SLEN_HI): sec_len = int'(b[3:0]) << 8;
                    int'(POS_SLEN_LO): sec_len = (sec_len | int'(b)) & 'h3ff;
                    int'(POS_CUR): is_current = b[0];
                    int'(POS_PIL_HI): pil = int'(b[3:0]) << 8;
                    int'(POS_PIL_LO): begin
                        pil = pil | int'(b);
                        if (!is_current) phase = PH_IDLE;
                        else if (pil != 0) phase = PH_PROG_INFO;
                        else to_es_header();
                    end
                    default: ;
                endcase
                return;
            end
            if (pos + 1 >= sec_len) begin
                phase = PH_IDLE;
                return;
            end
            case (phase)
                PH_PROG_INFO: begin
                    if (pos + 1 >= HDR_LEN + pil) to_es_header();
                end
                PH_ES_HDR: begin
                    case (hdr_cnt)
                        ES_HDR_TYPE: stype = b;
                        ES_HDR_PID_HI: spid = {b[4:0], 8'h00};
                        ES_HDR_PID_LO: spid = spid | {5'h00, b};
                        ES_HDR_LEN_HI: es_left = {b[3:0], 8'h00};
                        default: begin
                            es_left = es_left | {4'h0, b};
                            if (es_left == 0) to_es_header();
                            else if (stype == TYPE_PRIVATE) phase = PH_DESC_TAG;
                            else phase = PH_ES_SKIP;
                            hdr_cnt = '0;
                            return;
                        end
                    endcase
                    hdr_cnt++;
                end
                PH_ES_SKIP: begin
                    es_left--;
                    if (es_left == 0) to_es_header();
                end
                PH_DESC_TAG: begin
                    tag = b;
                    es_left--;
                    if (es_left == 0) to_es_header();
                    else phase = PH_DESC_LEN;
                end
                PH_DESC_LEN: begin
                    desc_left = b;
                    hdr_cnt = '0;
                    acc = '0;
                    es_left--;
                    if (es_left == 0) to_es_header();
                    else if (b == 0) phase = PH_DESC_TAG;
                    else phase = PH_DESC_BODY;
                end
                PH_DESC_BODY: begin
                    es_left--;
                    desc_left--;
                    if (tag == TAG_TELETEXT) begin
                        if (hdr_cnt < ENTRY_HDR_BYTES) begin
                            acc = {acc[23:0], b};
                            hdr_cnt++;
                        end else begin
                            push_entry(b);
                            hdr_cnt = '0;
                            acc = '0;
                        end
                    end
                    if (es_left == 0) to_es_header();
                    else if (desc_left == 0) phase = PH_DESC_TAG;
                end
                default: phase = PH_IDLE;
            endcase
        endfunction

        task report(string msg);
            $display("testbench: mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_entry(teletext_entry_t got);
            teletext_entry_t want;
            if (pending_entries.size() == 0) begin
                report($sformatf("entry for pid 0x%0h with nothing expected", got.pid));
                return;
            end
            want = pending_entries.pop_front();
            entries_checked++;
            if (want.remapped) remapped_seen++;
            check_field("stream_pid", 32'(got.pid), 32'(want.pid));
            check_field("language_code", 32'(got.lang), 32'(want.lang));
            check_field("page_type", 32'(got.ptype), 32'(want.ptype));
            check_field("magazine", 32'(got.mag), 32'(want.mag));
            check_field("page_number", 32'(got.page), 32'(want.page));
            check_field("page_was_remapped", 32'(got.remapped), 32'(want.remapped));
            check_field("entry_count", 32'(got.count), 32'(want.count));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;
    logic gaps_on;
    int idle_cycles;
    logic [7:0] section_q[$];
    teletext_entry_t seen_entry;
    teletext_scoreboard sb = new();

    ptd_byte_if section_ch();
    ptd_result_if entry_ch();

    pmt_teletext_descriptor_parser uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_byte(section_ch),
        .o_result(entry_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_ch.ready <= 1'b0;
        end else begin
            entry_ch.ready <= !(gaps_on && $urandom_range(99) < 19);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (entry_ch.valid && entry_ch.ready) begin
                seen_entry.pid = entry_ch.stream_pid;
                seen_entry.lang = entry_ch.language_code;
                seen_entry.ptype = entry_ch.page_type;
                seen_entry.mag = entry_ch.magazine;
                seen_entry.page = entry_ch.page_number;
                seen_entry.remapped = entry_ch.page_was_remapped;
                seen_entry.count = entry_ch.entry_count;
                sb.check_entry(seen_entry);
            end
            if (section_ch.valid && section_ch.ready)
                sb.parse_byte(section_ch.section_byte, section_ch.section_start);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (section_ch.valid && section_ch.ready) ||
                (entry_ch.valid && entry_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("testbench: no beat for %0d cycles", STALL_LIMIT);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic st);
        while (gaps_on && $urandom_range(99) < 19) begin
            section_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        section_ch.valid <= 1'b1;
        section_ch.section_byte <= b;
        section_ch.section_start <= st;
        @(posedge i_clk);
        while (!section_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_section(input int upto);
        for (int i = 0; i < upto; i++) send_byte(section_q[i], i == 0);
    endtask

    function automatic void add_descriptor(ref logic [7:0] q[$], input bit tidy);
        int n;
        int dlen;
        if ($urandom_range(3) != 0) begin
            n = $urandom_range(0, 4);
            dlen = 5 * n + ((!tidy && $urandom_range(1) == 1) ? $urandom_range(1, 4) : 0);
            q.push_back(TAG_TELETEXT);
            q.push_back(8'(dlen));
            repeat (n) begin
                repeat (4) q.push_back(8'($urandom));
                if ($urandom_range(1) == 1)
                    q.push_back(8'($urandom_range(PAGE_REMAP_LO - 2, PAGE_REMAP_HI + 2)));
                else
                    q.push_back(8'($urandom));
            end
            repeat (dlen - 5 * n) q.push_back(8'($urandom));
        end else begin
            dlen = $urandom_range(0, 6);
            q.push_back(8'($urandom));
            q.push_back(8'(dlen));
            repeat (dlen) q.push_back(8'($urandom));
        end
    endfunction

    function automatic void build_section(input int target, input bit current, input bit tidy);
        int pil;
        int esl;
        int len;
        logic [7:0] st;
        logic [12:0] pid;
        logic [7:0] es_info[$];
        section_q.delete();
        section_q.push_back(8'h02);
        section_q.push_back(8'h00);
        section_q.push_back(8'h00);
        repeat (2) section_q.push_back(8'($urandom));
        section_q.push_back({7'($urandom), current});
        repeat (4) section_q.push_back(8'($urandom));
        pil = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        section_q.push_back({4'($urandom), 4'(pil >> 8)});
        section_q.push_back(8'(pil));
        repeat (pil) section_q.push_back(8'($urandom));
        while (section_q.size() < target) begin
            es_info.delete();
            st = ($urandom_range(9) < 7) ? TYPE_PRIVATE : 8'($urandom);
            if (st == TYPE_PRIVATE)
                repeat ($urandom_range(0, 4)) add_descriptor(es_info, tidy);
            else
                repeat ($urandom_range(0, 6)) es_info.push_back(8'($urandom));
            esl = es_info.size();
            if (!tidy && $urandom_range(2) == 0) esl = $urandom_range(0, esl + 3);
            pid = 13'($urandom);
            section_q.push_back(st);
            section_q.push_back({3'($urandom), pid[12:8]});
            section_q.push_back(pid[7:0]);
            section_q.push_back({4'($urandom), 4'(esl >> 8)});
            section_q.push_back(8'(esl));
            foreach (es_info[i]) section_q.push_back(es_info[i]);
        end
        repeat (4) section_q.push_back(8'($urandom));
        len = section_q.size() - 3;
        if (!tidy && $urandom_range(1) == 1) len = $urandom_range(9, len + 4);
        if (len > 1023) len = 1023;
        section_q[1] = {4'($urandom), 2'($urandom), 2'(len >> 8)};
        section_q[2] = 8'(len);
    endfunction

    task automatic send_random_section();
        int pick;
        int upto;
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
        build_section($urandom_range(20, 80), !(pick >= 65 && pick < 75),
                      pick < 75 || pick >= 90);
        upto = (pick >= 90) ? $urandom_range(1, section_q.size() - 1) : section_q.size();
        send_section(upto);
    endtask

    task automatic drain();
        section_ch.valid <= 1'b0;
        while (sb.pending_entries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int bytes_mark;
        int entries_mark;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gaps_on = 1'b1;
        section_ch.valid = 1'b0;
        section_ch.section_byte = '0;
        section_ch.section_start = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            gaps_on <= (ph != 2);
            write_reg(REMAP_ADDR, 32'(ph % 2));
            sb.remap_on = (ph % 2 == 1);
            // Stray bytes first, then a minimal section with one entry at extreme values.
            send_byte(8'hFF, 1'b0);
            send_byte(8'h00, 1'b0);
            section_q = '{8'h02, 8'hB0, 8'd25, 8'h00, 8'h01, 8'hC1, 8'h00, 8'h00,
                          8'hE1, 8'h00, 8'hF0, 8'h00, TYPE_PRIVATE, 8'hFF, 8'hFF,
                          8'hF0, 8'h07, TAG_TELETEXT, 8'h05, 8'hFF, 8'hFF, 8'hFF,
                          8'hFF, PAGE_REMAP_HI, 8'h00};
            send_section(section_q.size());
            if (ph == 3) begin
                build_section(300, 1'b1, 1'b1);
                send_section(section_q.size());
            end
            bytes_mark = sb.bytes_seen;
            entries_mark = sb.entries_expected;
            while (sb.bytes_seen - bytes_mark < 100 || sb.entries_expected - entries_mark < 6)
                send_random_section();
            drain();
        end
        $display("testbench: %0d section bytes sent, %0d teletext entries checked, %0d remapped",
                 sb.bytes_seen, sb.entries_checked, sb.remapped_seen);
        $display("testbench: covered both remap settings, stale, cut and restarted sections");
        if (sb.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
